// ===== rtl/nffa_pkg.sv =====
`default_nettype none

package nffa_pkg;

   // item kinds
   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   // result status codes
   localparam logic [1:0] ST_FOUND     = 2'd0;
   localparam logic [1:0] ST_EMPTY     = 2'd1;
   localparam logic [1:0] ST_NO_ANCHOR = 2'd2;

   // register indexes (byte address is 4 * index)
   localparam logic [1:0] REG_ENTRY_COUNT = 2'd0;
   localparam logic [1:0] REG_ANCHOR_FLOOR = 2'd1;
   localparam logic [1:0] REG_ANCHOR_ALT = 2'd2;

   localparam int ADDR_W = 4;
   localparam int DATA_W = 32;

   // datapath widths: offsets grow one bit per add
   localparam int MEAS_OFF_W = 33;
   localparam int BASE_W     = 34;
   localparam int ALU_W      = 35;
   localparam int MAG_W      = 34;

   typedef struct packed {
      logic               action;
      logic [3:0]         entry_index;
      logic signed [7:0]  entry_floor;
      logic signed [31:0] entry_height;
      logic signed [31:0] measured_altitude;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic signed [7:0] floor_number;
   } rsp_type;

   typedef struct packed {
      logic signed [7:0]  floor_id;
      logic signed [31:0] height;
   } entry_type;

   typedef struct packed {
      logic [4:0]         entry_count;
      logic signed [7:0]  anchor_floor;
      logic signed [31:0] anchor_altitude;
   } cfg_type;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      alu_op_type              op;
      logic signed [ALU_W-1:0] a;
      logic signed [ALU_W-1:0] b;
   } alu_cmd_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_BASE,
      S_SEARCH
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/nffa_alu.sv =====
`default_nettype none

// shared add / subtract unit
module nffa_alu import nffa_pkg::*; (
   input  alu_cmd_type             cmd,
   output logic signed [ALU_W-1:0] result
);

   always_comb begin
      unique case (cmd.op)
         ALU_ADD: result = cmd.a + cmd.b;
         ALU_SUB: result = cmd.a - cmd.b;
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/nffa_table.sv =====
`default_nettype none

// floor table, one write and one registered read port
module nffa_table import nffa_pkg::*; #(
   parameter int MAX_FLOORS = 16,
   localparam int IDX_W = (MAX_FLOORS > 1) ? $clog2(MAX_FLOORS) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  entry_type        wr_data,
   input  logic [IDX_W-1:0] rd_addr,
   output entry_type        rd_data
);

   entry_type mem [0:MAX_FLOORS-1];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/nffa_csr.sv =====
`default_nettype none

// configuration registers on the apb-style port
module nffa_csr import nffa_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_word;
   logic [1:0] reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[3:2];
   assign wr_word = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_word) begin
         unique case (reg_idx)
            REG_ENTRY_COUNT:  cfg_in.entry_count     = pwdata[4:0];
            REG_ANCHOR_FLOOR: cfg_in.anchor_floor    = pwdata[7:0];
            REG_ANCHOR_ALT:   cfg_in.anchor_altitude = pwdata[31:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_ENTRY_COUNT:  prdata = {27'd0, cfg_ff.entry_count};
         REG_ANCHOR_FLOOR: prdata = {{24{cfg_ff.anchor_floor[7]}}, cfg_ff.anchor_floor};
         REG_ANCHOR_ALT:   prdata = cfg_ff.anchor_altitude;
         default:          prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== rtl/nffa_ctrl.sv =====
`default_nettype none

// sequencer: anchor scan, base setup, nearest search
module nffa_ctrl import nffa_pkg::*; #(
   parameter int MAX_FLOORS = 16,
   localparam int IDX_W = (MAX_FLOORS > 1) ? $clog2(MAX_FLOORS) : 1,
   localparam int CNT_W = $clog2(MAX_FLOORS + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  req_type                 req_item,
   input  cfg_type                 cfg,
   output logic                    wr_en,
   output logic [IDX_W-1:0]        wr_addr,
   output entry_type               wr_data,
   output logic [IDX_W-1:0]        rd_addr,
   input  entry_type               rd_data,
   output alu_cmd_type             alu_cmd,
   input  logic signed [ALU_W-1:0] alu_result,
   output logic                    rsp_valid,
   output rsp_type                 rsp_item
);

   state_type state_ff, state_in;

   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic             rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;

   logic signed [31:0]         meas_ff, meas_in;
   logic signed [MEAS_OFF_W-1:0] meas_off_ff, meas_off_in;
   logic signed [31:0]         anchor_h_ff, anchor_h_in;
   logic signed [BASE_W-1:0]   base_ff, base_in;

   logic                    e_vld_ff, e_vld_in;
   logic [IDX_W-1:0]        e_idx_ff, e_idx_in;
   logic signed [7:0]       e_floor_ff, e_floor_in;
   logic signed [ALU_W-1:0] e_diff_ff, e_diff_in;

   logic [MAG_W-1:0]  best_mag_ff, best_mag_in;
   logic signed [7:0] best_floor_ff, best_floor_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_item_ff, rsp_item_in;

   logic                    accept;
   logic                    query_acc;
   logic [CNT_W-1:0]        count_lim;
   logic [CNT_W-1:0]        last_idx;
   logic                    match;
   logic                    last_rd;
   logic                    last_e;
   logic                    more;
   logic signed [ALU_W-1:0] neg_diff;
   logic [MAG_W-1:0]        mag;
   logic                    take;
   logic [IDX_W+3:0]        idx_wide;

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign query_acc = accept && (req_item.action == ACT_QUERY);

   // saturate the entry count at the table depth
   assign count_lim = ({27'd0, cfg.entry_count} > 32'(MAX_FLOORS)) ?
                      CNT_W'(MAX_FLOORS) : CNT_W'(cfg.entry_count);
   assign last_idx  = count_lim - CNT_W'(1);
   assign more      = (ptr_ff < count_lim);

   assign match   = rd_vld_ff && (rd_data.floor_id == cfg.anchor_floor);
   assign last_rd = rd_vld_ff && (CNT_W'(rd_idx_ff) == last_idx);
   assign last_e  = e_vld_ff && (CNT_W'(e_idx_ff) == last_idx);

   // table writes straight from the accepted word
   assign idx_wide = {{IDX_W{1'b0}}, req_item.entry_index};
   assign wr_en    = accept && (req_item.action == ACT_WRITE) &&
                     ({28'd0, req_item.entry_index} < 32'(MAX_FLOORS));
   assign wr_addr  = idx_wide[IDX_W-1:0];
   assign wr_data  = {req_item.entry_floor, req_item.entry_height};
   assign rd_addr  = ptr_ff[IDX_W-1:0];

   // magnitude of the registered difference
   assign neg_diff = -e_diff_ff;
   assign mag      = e_diff_ff[ALU_W-1] ? neg_diff[MAG_W-1:0] : e_diff_ff[MAG_W-1:0];
   assign take     = e_vld_ff && ((e_idx_ff == '0) || (mag < best_mag_ff));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (query_acc && (count_lim != '0)) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (match) begin
               state_in = S_BASE;
            end else if (last_rd) begin
               state_in = S_IDLE;
            end
         end
         S_BASE: begin
            state_in = S_SEARCH;
         end
         S_SEARCH: begin
            if (last_e) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      ptr_in        = ptr_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = ptr_ff[IDX_W-1:0];
      meas_in       = query_acc ? req_item.measured_altitude : meas_ff;
      meas_off_in   = meas_off_ff;
      anchor_h_in   = anchor_h_ff;
      base_in       = base_ff;
      e_vld_in      = 1'b0;
      e_idx_in      = rd_idx_ff;
      e_floor_in    = rd_data.floor_id;
      e_diff_in     = alu_result;
      best_mag_in   = take ? mag : best_mag_ff;
      best_floor_in = take ? e_floor_ff : best_floor_ff;
      rsp_valid_in  = 1'b0;
      rsp_item_in   = rsp_item_ff;
      alu_cmd.op    = ALU_SUB;
      alu_cmd.a     = ALU_W'(meas_ff);
      alu_cmd.b     = ALU_W'(cfg.anchor_altitude);

      unique case (state_ff)
         S_IDLE: begin
            ptr_in = '0;
            if (query_acc && (count_lim == '0)) begin
               rsp_valid_in             = 1'b1;
               rsp_item_in.status       = ST_EMPTY;
               rsp_item_in.floor_number = '0;
            end
         end
         S_SCAN: begin
            // alu forms measured offset while the table streams by
            meas_off_in = alu_result[MEAS_OFF_W-1:0];
            if (more) begin
               ptr_in    = ptr_ff + CNT_W'(1);
               rd_vld_in = 1'b1;
            end
            if (match) begin
               anchor_h_in = rd_data.height;
            end else if (last_rd) begin
               rsp_valid_in             = 1'b1;
               rsp_item_in.status       = ST_NO_ANCHOR;
               rsp_item_in.floor_number = '0;
            end
         end
         S_BASE: begin
            // base = anchor height + measured offset
            ptr_in    = '0;
            alu_cmd.op = ALU_ADD;
            alu_cmd.a  = ALU_W'(anchor_h_ff);
            alu_cmd.b  = ALU_W'(meas_off_ff);
            base_in    = alu_result[BASE_W-1:0];
         end
         S_SEARCH: begin
            alu_cmd.op = ALU_SUB;
            alu_cmd.a  = ALU_W'(rd_data.height);
            alu_cmd.b  = ALU_W'(base_ff);
            e_vld_in   = rd_vld_ff;
            if (more) begin
               ptr_in    = ptr_ff + CNT_W'(1);
               rd_vld_in = 1'b1;
            end
            if (last_e) begin
               rsp_valid_in             = 1'b1;
               rsp_item_in.status       = ST_FOUND;
               rsp_item_in.floor_number = take ? e_floor_ff : best_floor_ff;
            end
         end
         default: begin
            ptr_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ptr_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         e_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         rd_vld_ff    <= rd_vld_in;
         e_vld_ff     <= e_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_idx_in;
      meas_ff       <= meas_in;
      meas_off_ff   <= meas_off_in;
      anchor_h_ff   <= anchor_h_in;
      base_ff       <= base_in;
      e_idx_ff      <= e_idx_in;
      e_floor_ff    <= e_floor_in;
      e_diff_ff     <= e_diff_in;
      best_mag_ff   <= best_mag_in;
      best_floor_ff <= best_floor_in;
      rsp_item_ff   <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

`default_nettype wire

// ===== rtl/nearest_floor_from_altitude_unit.sv =====
// nearest floor from altitude. a word with action write stores {floor, height}
// in the table slot entry_index in the accept cycle (busy stays low, no
// result; slots at or beyond MAX_FLOORS are dropped). a query word finds the
// first entry in use whose floor equals anchor_floor, then returns the floor
// whose height offset from that anchor best matches measured_altitude minus
// anchor_altitude (least absolute difference, ties keep the lower index).
// busy is high while a query runs. the entries in use are the first entry_count
// slots, saturated at MAX_FLOORS. an empty table answers in the cycle after
// accept, and a query with no anchor ends after the first pass. a query makes
// two passes over the single read port of the table, one entry per cycle, plus
// a setup step on the shared adder. each result shows on rsp_item for exactly
// one cycle with rsp_valid; there is no backpressure, so the receiver must
// take it then. configuration writes only while idle.

`default_nettype none

module nearest_floor_from_altitude_unit import nffa_pkg::*; #(
   parameter int MAX_FLOORS = 16
) (
   input  logic              clock,
   input  logic              reset,

   // command channel
   input  logic              start,
   output logic              busy,
   input  req_type           req_item,

   // result channel
   output logic              rsp_valid,
   output rsp_type           rsp_item,

   // configuration port
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   localparam int IDX_W = (MAX_FLOORS > 1) ? $clog2(MAX_FLOORS) : 1;

   cfg_type                 cfg;
   logic                    wr_en;
   logic [IDX_W-1:0]        wr_addr;
   entry_type               wr_data;
   logic [IDX_W-1:0]        rd_addr;
   entry_type               rd_data;
   alu_cmd_type             alu_cmd;
   logic signed [ALU_W-1:0] alu_result;

   // register file: entry_count, anchor_floor, anchor_altitude
   nffa_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // table memory, read data registered
   nffa_table #(
      .MAX_FLOORS (MAX_FLOORS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // one 35-bit adder shared by offset, base and per-entry difference
   nffa_alu u_alu (
      .cmd    (alu_cmd),
      .result (alu_result)
   );

   // sequencer: scan for anchor, form base, then search for the nearest entry
   nffa_ctrl #(
      .MAX_FLOORS (MAX_FLOORS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .cfg        (cfg),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .alu_cmd    (alu_cmd),
      .alu_result (alu_result),
      .rsp_valid  (rsp_valid),
      .rsp_item   (rsp_item)
   );

   // a result only leaves as the sequencer returns to idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // failed lookups report floor zero
   a_zero_floor: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item.status != ST_FOUND)) |-> (rsp_item.floor_number == '0))
      else $error("nonzero floor on failed lookup");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_item.status == ST_FOUND) || (rsp_item.status == ST_EMPTY) ||
                     (rsp_item.status == ST_NO_ANCHOR)))
      else $error("illegal status code");

   // a table write never produces a result
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_item.action == ACT_WRITE)) |=> !rsp_valid)
      else $error("result after table write");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import nffa_pkg::*;

   localparam int TABLE_DEPTH     = 16;
   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int RANDOM_PHASES   = 12;
   localparam int WORDS_PER_PHASE = 170;
   // longest query is two passes over the table plus setup
   localparam int DRAIN_CYCLES    = 2 * TABLE_DEPTH + 12;
   localparam int SHOW_LIMIT      = 10;
   // register slot past the end of the list, writes there must be dropped
   localparam logic [1:0] REG_SPARE = 2'd3;

   logic              clock = 1'b0;
   logic              reset;
   logic              start;
   logic              busy;
   req_type           req_item;
   logic              rsp_valid;
   rsp_type           rsp_item;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   // local copy of the floor table and the registers
   entry_type floor_table_model [TABLE_DEPTH];
   cfg_type   cfg_model;
   // answers still owed by the block, oldest first
   rsp_type   floor_answers [$];

   int cycle_count;
   int fail_count;
   int results_checked;
   int write_words;
   int query_words;
   int found_count;
   int empty_count;
   int no_anchor_count;
   int csr_writes;

   nearest_floor_from_altitude_unit #(
      .MAX_FLOORS(TABLE_DEPTH)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_item (rsp_item),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always #1 clock = ~clock;

   // watchdog: a hung handshake or a missing answer ends here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d answers outstanding",
                  cycle_count, floor_answers.size());
         $display("testbench failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------------

   // entry_count saturates at the table depth
   function automatic int entries_in_use();
      return (cfg_model.entry_count > TABLE_DEPTH) ? TABLE_DEPTH
                                                   : int'(cfg_model.entry_count);
   endfunction

   // first slot in use holding the anchor floor, -1 when absent
   function automatic int find_anchor(input int n);
      for (int i = 0; i < n; i++)
         if (floor_table_model[i].floor_id == cfg_model.anchor_floor)
            return i;
      return -1;
   endfunction

   // least |(h_i - h_anchor) - (alt - anchor_alt)|, all at 34 bits
   function automatic rsp_type nearest_floor(input logic signed [31:0] altitude);
      int                 n;
      int                 a;
      logic signed [33:0] alt_off;
      logic signed [33:0] anchor_alt;
      logic signed [33:0] base;
      logic signed [33:0] height;
      logic signed [33:0] diff;
      logic [33:0]        mag;
      logic [33:0]        best_mag;
      rsp_type            r;
      r.status       = ST_FOUND;
      r.floor_number = '0;
      best_mag       = '0;
      n = entries_in_use();
      a = find_anchor(n);
      if (n == 0) begin
         r.status = ST_EMPTY;
      end else if (a < 0) begin
         r.status = ST_NO_ANCHOR;
      end else begin
         alt_off    = altitude;
         anchor_alt = cfg_model.anchor_altitude;
         alt_off    = alt_off - anchor_alt;
         base       = floor_table_model[a].height;
         for (int i = 0; i < n; i++) begin
            height = floor_table_model[i].height;
            diff   = (height - base) - alt_off;
            mag    = (diff < 0) ? -diff : diff;
            // strict compare keeps the earlier slot on a tie
            if (i == 0 || mag < best_mag) begin
               best_mag       = mag;
               r.floor_number = floor_table_model[i].floor_id;
            end
         end
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // checking: every rsp_valid cycle must match the oldest answer owed
   // ---------------------------------------------------------------------

   always @(posedge clock) begin : check_answers
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (floor_answers.size() == 0) begin
            fail_count++;
            if (fail_count <= SHOW_LIMIT)
               $display("unexpected result: status %0d floor %0d",
                        rsp_item.status, rsp_item.floor_number);
         end else begin
            want = floor_answers.pop_front();
            results_checked++;
            if (rsp_item.status !== want.status ||
                rsp_item.floor_number !== want.floor_number) begin
               fail_count++;
               if (fail_count <= SHOW_LIMIT)
                  $display("result %0d: expected status %0d floor %0d, got status %0d floor %0d",
                           results_checked, want.status, want.floor_number,
                           rsp_item.status, rsp_item.floor_number);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------------

   // present one word and hold it until start && !busy at an edge;
   // start stays high so a following word can go back to back
   task automatic send_word(input req_type w);
      rsp_type answer;
      start    <= 1'b1;
      req_item <= w;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (w.action == ACT_QUERY) begin
         answer = nearest_floor(w.measured_altitude);
         floor_answers.push_back(answer);
         query_words++;
         case (answer.status)
            ST_FOUND:     found_count++;
            ST_EMPTY:     empty_count++;
            ST_NO_ANCHOR: no_anchor_count++;
            default: ;
         endcase
      end else begin
         floor_table_model[w.entry_index] = '{floor_id: w.entry_floor,
                                              height: w.entry_height};
         write_words++;
      end
   endtask

   task automatic pause(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // block idle: nothing owed and no query in flight
   task automatic wait_idle();
      start <= 1'b0;
      while (floor_answers.size() != 0 || busy) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // setup cycle, access cycle, then an idle cycle so psel drops between writes
   task automatic csr_write(input logic [1:0] index, input logic [DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (index)
         REG_ENTRY_COUNT:  cfg_model.entry_count     = value[4:0];
         REG_ANCHOR_FLOOR: cfg_model.anchor_floor    = value[7:0];
         REG_ANCHOR_ALT:   cfg_model.anchor_altitude = value;
         default: ;
      endcase
      csr_writes++;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // the unused upper bits of the narrow registers carry junk half the time
   task automatic set_config(input int count, input logic signed [7:0] anchor_fl,
                             input logic [31:0] anchor_alt);
      logic [31:0] v;
      v      = $urandom;
      v[4:0] = count[4:0];
      if ($urandom_range(0, 1) != 0) v[31:5] = '0;
      csr_write(REG_ENTRY_COUNT, v);
      v      = $urandom;
      v[7:0] = anchor_fl;
      if ($urandom_range(0, 1) != 0) v[31:8] = '0;
      csr_write(REG_ANCHOR_FLOOR, v);
      csr_write(REG_ANCHOR_ALT, anchor_alt);
   endtask

   task automatic query_altitude(input logic signed [31:0] alt);
      req_type w;
      logic [31:0] r;
      r                   = $urandom;
      w.action            = ACT_QUERY;
      w.entry_index       = r[3:0];
      w.entry_floor       = r[11:4];
      w.entry_height      = $urandom;
      w.measured_altitude = alt;
      send_word(w);
   endtask

   task automatic load_entry(input logic [3:0] idx, input logic signed [7:0] fl,
                             input logic signed [31:0] height);
      req_type w;
      w.action            = ACT_WRITE;
      w.entry_index       = idx;
      w.entry_floor       = fl;
      w.entry_height      = height;
      w.measured_altitude = $urandom;
      send_word(w);
   endtask

   // random word biased toward floors near the anchor and altitudes near
   // a table entry, so the search actually has to pick among neighbors
   function automatic req_type random_word();
      req_type     w;
      logic [31:0] r;
      int          n;
      int          a;
      int          i;
      int          roll;
      r                   = $urandom;
      w.action            = r[0];
      w.entry_index       = r[4:1];
      w.entry_floor       = r[12:5];
      w.entry_height      = $urandom;
      w.measured_altitude = $urandom;
      n    = entries_in_use();
      a    = find_anchor(n);
      roll = $urandom_range(0, 99);
      if (roll < 25) begin
         w.action = ACT_WRITE;
         if (n > 0 && $urandom_range(0, 2) != 0)
            w.entry_index = 4'($urandom_range(0, n - 1));
         if ($urandom_range(0, 3) != 0) begin
            w.entry_floor  = cfg_model.anchor_floor + 8'($urandom_range(0, 6)) - 8'd3;
            w.entry_height = 32'(int'(w.entry_floor) * 3000 + $urandom_range(0, 999));
         end
      end else begin
         w.action = ACT_QUERY;
         if (roll < 85 && a >= 0) begin
            i = $urandom_range(0, n - 1);
            w.measured_altitude = cfg_model.anchor_altitude + floor_table_model[i].height
                                  - floor_table_model[a].height
                                  + 32'($urandom_range(0, 4000)) - 32'd2000;
         end
      end
      return w;
   endfunction

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // entry_count is zero out of reset, so no table slot is read
   task automatic test_empty_table();
      query_altitude($urandom);
   endtask

   // fill every slot before any query reads the table; includes both
   // floor extremes, both height extremes, a height tie and a repeated floor
   task automatic test_table_load();
      wait_idle();
      load_entry(4'd0,  -8'sd128, 32'sh8000_0000);
      load_entry(4'd1,  -8'sd2,   -32'sd6000);
      load_entry(4'd2,  -8'sd1,   -32'sd3000);
      load_entry(4'd3,  8'sd0,    32'sd0);
      load_entry(4'd4,  8'sd1,    32'sd3000);
      load_entry(4'd5,  8'sd2,    32'sd3000);
      load_entry(4'd6,  8'sd3,    32'sd6000);
      load_entry(4'd7,  8'sd3,    32'sd9000);
      for (int i = 8; i < 15; i++)
         load_entry(4'(i), 8'(i - 4), 32'((i - 4) * 3000));
      load_entry(4'd15, 8'sd127,  32'sh7FFF_FFFF);
   endtask

   // ties: slots 4 and 5 share a height, 1500 sits midway between floors 0 and 1
   task automatic test_nearest_and_ties();
      wait_idle();
      set_config(16, 8'sd0, 32'd0);
      query_altitude(32'sd3000);
      query_altitude(32'sd1500);
   endtask

   // altitude offsets spanning the full 33-bit range
   task automatic test_extreme_values();
      wait_idle();
      set_config(16, 8'sd0, 32'h8000_0000);
      query_altitude(32'sh7FFF_FFFF);
      wait_idle();
      // anchor in the last slot
      set_config(16, 8'sd127, 32'h7FFF_FFFF);
      query_altitude(32'sh8000_0000);
   endtask

   // repeated anchor floor uses the first slot; then an anchor not in the table
   task automatic test_anchor_cases();
      wait_idle();
      set_config(16, 8'sd3, 32'd0);
      query_altitude(32'sd3000);
      wait_idle();
      set_config(16, -8'sd100, 32'd0);
      query_altitude(32'sd0);
   endtask

   // saturation above the depth, a single entry, anchor outside the slots
   // in use, and a write to the spare register slot
   task automatic test_entry_count();
      wait_idle();
      set_config(31, 8'sd0, 32'd0);
      query_altitude(32'sh7FFF_FFFF);
      wait_idle();
      set_config(1, -8'sd128, 32'd12345);
      query_altitude($urandom);
      wait_idle();
      set_config(3, 8'sd0, 32'd0);
      query_altitude(32'sd0);
      wait_idle();
      csr_write(REG_SPARE, $urandom);
      query_altitude(32'sd0);
   endtask

   // each phase picks new settings, the first few are the extremes
   task automatic random_settings(input int phase);
      int                 count;
      int                 n;
      logic signed [7:0]  anchor_fl;
      logic [31:0]        anchor_alt;
      case (phase)
         0: count = 16;
         1: count = 1;
         2: count = 31;
         3: count = 0;
         default: count = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 31)
                                                      : $urandom_range(1, 16);
      endcase
      n = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
      if (n > 0 && $urandom_range(0, 4) != 0)
         anchor_fl = floor_table_model[$urandom_range(0, n - 1)].floor_id;
      else
         anchor_fl = 8'($urandom);
      case ($urandom_range(0, 3))
         0: anchor_alt = $urandom;
         1: anchor_alt = 32'h7FFF_FFFF;
         2: anchor_alt = 32'h8000_0000;
         default: anchor_alt = 32'($urandom_range(0, 20000)) - 32'd10000;
      endcase
      set_config(count, anchor_fl, anchor_alt);
   endtask

   // bursts of words with random gaps; one phase in five runs with no gaps
   task automatic test_random_traffic();
      int sent;
      int burst;
      int gap;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_idle();
         random_settings(phase);
         sent = 0;
         while (sent < WORDS_PER_PHASE) begin
            burst = $urandom_range(1, 24);
            repeat (burst) begin
               send_word(random_word());
               sent++;
            end
            if (phase % 5 != 4) begin
               gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 45)
                                                 : $urandom_range(1, 6);
               pause(gap);
            end
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------

   initial begin
      reset    <= 1'b1;
      start    <= 1'b0;
      req_item <= '0;
      psel     <= 1'b0;
      penable  <= 1'b0;
      pwrite   <= 1'b0;
      paddr    <= '0;
      pwdata   <= '0;
      cfg_model = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) floor_table_model[i] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_table();
      test_table_load();
      test_nearest_and_ties();
      test_extreme_values();
      test_anchor_cases();
      test_entry_count();
      test_random_traffic();

      // drain, then leave room for any stray result
      start <= 1'b0;
      while (floor_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d table writes, %0d queries (%0d found, %0d empty, %0d no anchor)",
               write_words, query_words, found_count, empty_count, no_anchor_count);
      $display("%0d register writes, %0d results checked, %0d failures",
               csr_writes, results_checked, fail_count);
      if (fail_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
